/* hw/rtl/memory_to_memory_instruction_executor_unit_assert.svh */
// Assertion macros for the executor RTL.
`ifndef MEMORY_TO_MEMORY_INSTRUCTION_EXECUTOR_UNIT_ASSERT_SVH
`define MEMORY_TO_MEMORY_INSTRUCTION_EXECUTOR_UNIT_ASSERT_SVH

// Check a condition in the same cycle as its trigger
`define MMIE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its trigger
`define MMIE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/mmie_pkg.sv */
package mmie_pkg;

  // Data memory geometry
  localparam int unsigned DATA_WORDS = 16;
  localparam int unsigned ADDR_W     = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;

  // Field widths
  localparam int unsigned CMD_W   = 4;
  localparam int unsigned PC_W    = 16;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned WIDX_W  = 8;
  localparam int unsigned STAT_W  = 2;

  // Stream widths, padded to whole bytes
  localparam int unsigned IN_BITS   = CMD_W + PC_W + 2 * WORD_W;
  localparam int unsigned IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS   = STAT_W + PC_W + 1 + 1 + WIDX_W + WORD_W;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    OP_ADD  = 4'd0,
    OP_ADDI = 4'd1,
    OP_SUB  = 4'd2,
    OP_SUBI = 4'd3,
    OP_MOV  = 4'd4,
    OP_MOVI = 4'd5,
    OP_B    = 4'd6,
    OP_BEQ  = 4'd7,
    OP_BEQI = 4'd8,
    OP_BNE  = 4'd9,
    OP_BNEI = 4'd10
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_MALFORMED = 2'd2
  } status_t;

  // One instruction request
  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic [PC_W-1:0]          target;
    logic signed [WORD_W-1:0] first_operand;
    logic signed [WORD_W-1:0] second_operand;
  } instr_t;

  // One result
  typedef struct packed {
    status_t                  status;
    logic [PC_W-1:0]          next_pc;
    logic                     halted;
    logic                     wrote;
    logic [WIDX_W-1:0]        write_index;
    logic signed [WORD_W-1:0] write_value;
  } result_t;

endpackage

/* hw/rtl/mmie_ram.sv */
module mmie_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_a,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_b,
  output logic [WIDTH-1:0]                 rdata_a,
  output logic [WIDTH-1:0]                 rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Two registered read ports, old data on a same-edge write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

/* hw/rtl/mmie_exec.sv */
module mmie_exec (
  input  mmie_pkg::instr_t                    instr,
  input  logic [mmie_pkg::WORD_W-1:0]         x_val,
  input  logic [mmie_pkg::WORD_W-1:0]         y_val,
  input  logic [mmie_pkg::PC_W-1:0]           pc,
  input  logic [mmie_pkg::PC_W-1:0]           prog_len,
  output mmie_pkg::result_t                   res,
  output logic [mmie_pkg::ADDR_W-1:0]         wr_addr
);

  logic                        t_data;
  logic                        t_prog;
  logic                        a_ok;
  logic                        b_ok;
  logic [mmie_pkg::PC_W-1:0]   pc_inc;
  logic [mmie_pkg::WORD_W-1:0] imm;
  logic [mmie_pkg::WORD_W-1:0] wval;
  logic                        wr;
  logic                        take;
  logic                        eq_mem;
  logic                        eq_imm;
  mmie_pkg::status_t           status;
  logic [mmie_pkg::PC_W-1:0]   npc;

  // Range checks; negative operands fail the unsigned compare
  assign t_data = instr.target < mmie_pkg::PC_W'(mmie_pkg::DATA_WORDS);
  assign t_prog = instr.target < prog_len;
  assign a_ok   = $unsigned(instr.first_operand)
                  < mmie_pkg::WORD_W'(mmie_pkg::DATA_WORDS);
  assign b_ok   = $unsigned(instr.second_operand)
                  < mmie_pkg::WORD_W'(mmie_pkg::DATA_WORDS);
  assign pc_inc = pc + mmie_pkg::PC_W'(1);
  assign imm    = $unsigned(instr.second_operand);
  assign eq_mem = x_val == y_val;
  assign eq_imm = x_val == imm;

  // Decode and execute
  always_comb begin
    status = mmie_pkg::ST_OK;
    wr     = 1'b0;
    wval   = '0;
    take   = 1'b0;
    unique case (instr.command) inside
      mmie_pkg::OP_ADD, mmie_pkg::OP_SUB: begin
        if (t_data && a_ok && b_ok) begin
          wr   = 1'b1;
          wval = (instr.command == mmie_pkg::OP_ADD) ? x_val + y_val : x_val - y_val;
        end else begin
          status = mmie_pkg::ST_RANGE;
        end
      end
      mmie_pkg::OP_ADDI, mmie_pkg::OP_SUBI, mmie_pkg::OP_MOV: begin
        if (t_data && a_ok) begin
          wr = 1'b1;
          unique case (instr.command) inside
            mmie_pkg::OP_ADDI: wval = x_val + imm;
            mmie_pkg::OP_SUBI: wval = x_val - imm;
            default:           wval = x_val;
          endcase
        end else begin
          status = mmie_pkg::ST_RANGE;
        end
      end
      mmie_pkg::OP_MOVI: begin
        if (t_data) begin
          wr   = 1'b1;
          wval = $unsigned(instr.first_operand);
        end else begin
          status = mmie_pkg::ST_RANGE;
        end
      end
      mmie_pkg::OP_B: begin
        if (t_prog) begin
          take = 1'b1;
        end else begin
          status = mmie_pkg::ST_RANGE;
        end
      end
      mmie_pkg::OP_BEQ, mmie_pkg::OP_BNE: begin
        if (t_prog && a_ok && b_ok) begin
          take = (instr.command == mmie_pkg::OP_BEQ) ? eq_mem : !eq_mem;
        end else begin
          status = mmie_pkg::ST_RANGE;
        end
      end
      mmie_pkg::OP_BEQI, mmie_pkg::OP_BNEI: begin
        if (t_prog && a_ok) begin
          take = (instr.command == mmie_pkg::OP_BEQI) ? eq_imm : !eq_imm;
        end else begin
          status = mmie_pkg::ST_RANGE;
        end
      end
      default: begin
        status = mmie_pkg::ST_MALFORMED;
      end
    endcase
  end

  // Redirect the counter on a taken branch
  assign npc     = take ? instr.target : pc_inc;
  assign wr_addr = instr.target[mmie_pkg::ADDR_W-1:0];

  // Pack the result; index and value read zero when nothing is written
  always_comb begin
    res.status      = status;
    res.next_pc     = npc;
    res.halted      = npc >= prog_len;
    res.wrote       = wr;
    res.write_index = wr ? mmie_pkg::WIDX_W'(instr.target[mmie_pkg::ADDR_W-1:0]) : '0;
    res.write_value = wr ? $signed(wval) : '0;
  end

endmodule

/* hw/rtl/memory_to_memory_instruction_executor_unit.sv */
// Memory-to-memory instruction executor. Each request on in_* is one instruction
// run against a 16-word data memory (reading as zero after reset) and a 16-bit
// program counter; each instruction returns exactly one result on out_*. A
// request is accepted every cycle when the result side keeps up: the operand
// reads are issued at acceptance as the request enters the execute stage, and
// the result is registered once the result register is free or draining.
// Back-to-back dependent instructions are handled by forwarding the word being
// written. The rate is set by the single data memory write port and the one-pass
// execute stage. The user writes program_length via cfg_wr_en/cfg_wr_data only
// while no instruction is in flight; the block itself does not enforce this.
`include "memory_to_memory_instruction_executor_unit_assert.svh"

module memory_to_memory_instruction_executor_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // Instruction requests
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [3:0] command, [19:4] target, [51:20] first_operand,
  // [83:52] second_operand, [87:84] zero
  input  logic [mmie_pkg::IN_DATA_W-1:0]      in_tdata,
  // Results
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [1:0] status, [17:2] next_pc, [18] halted, [19] wrote,
  // [27:20] write_index, [59:28] write_value, [63:60] zero
  output logic [mmie_pkg::OUT_DATA_W-1:0]     out_tdata,
  // program_length register
  input  logic                                cfg_wr_en,
  input  logic [mmie_pkg::PC_W-1:0]           cfg_wr_data
);

  mmie_pkg::instr_t                 in_instr;
  logic                             in_acc;
  logic [mmie_pkg::ADDR_W-1:0]      a_idx;
  logic [mmie_pkg::ADDR_W-1:0]      b_idx;

  logic                             s1_v_r;
  mmie_pkg::instr_t                 s1_instr_r;
  logic                             s1_go;
  logic                             vld_a_r;
  logic                             vld_b_r;
  logic                             fwd_a_r;
  logic                             fwd_b_r;
  logic [mmie_pkg::WORD_W-1:0]      fwd_val_r;
  logic [mmie_pkg::WORD_W-1:0]      ram_qa;
  logic [mmie_pkg::WORD_W-1:0]      ram_qb;
  logic [mmie_pkg::WORD_W-1:0]      x_val;
  logic [mmie_pkg::WORD_W-1:0]      y_val;

  logic [mmie_pkg::DATA_WORDS-1:0]  valid_r;
  logic [mmie_pkg::PC_W-1:0]        pc_r;
  logic [mmie_pkg::PC_W-1:0]        prog_len_r;

  mmie_pkg::result_t                res;
  logic [mmie_pkg::ADDR_W-1:0]      wr_addr;
  logic                             ram_we;

  logic                             out_v_r;
  mmie_pkg::result_t                out_res_r;

  // Unpack the request, lowest field first
  assign in_instr.command        = in_tdata[3:0];
  assign in_instr.target         = in_tdata[19:4];
  assign in_instr.first_operand  = $signed(in_tdata[51:20]);
  assign in_instr.second_operand = $signed(in_tdata[83:52]);

  assign a_idx = in_instr.first_operand[mmie_pkg::ADDR_W-1:0];
  assign b_idx = in_instr.second_operand[mmie_pkg::ADDR_W-1:0];

  // Execute stage advances when the result register is free or draining
  assign s1_go     = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_go;
  assign in_acc    = in_tvalid && in_tready;
  assign ram_we    = s1_go && res.wrote;

  mmie_ram #(
    .WIDTH (mmie_pkg::WORD_W),
    .DEPTH (mmie_pkg::DATA_WORDS)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (wr_addr),
    .wdata   ($unsigned(res.write_value)),
    .re      (in_acc),
    .raddr_a (a_idx),
    .raddr_b (b_idx),
    .rdata_a (ram_qa),
    .rdata_b (ram_qb)
  );

  // Hold the request and its operand bypass state in the execute stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_instr_r <= in_instr;
      vld_a_r    <= valid_r[a_idx];
      vld_b_r    <= valid_r[b_idx];
      fwd_a_r    <= ram_we && (wr_addr == a_idx);
      fwd_b_r    <= ram_we && (wr_addr == b_idx);
      fwd_val_r  <= $unsigned(res.write_value);
    end
  end

  // Select forwarded, stored or cleared word
  assign x_val = fwd_a_r ? fwd_val_r : (vld_a_r ? ram_qa : '0);
  assign y_val = fwd_b_r ? fwd_val_r : (vld_b_r ? ram_qb : '0);

  mmie_exec u_exec (
    .instr    (s1_instr_r),
    .x_val    (x_val),
    .y_val    (y_val),
    .pc       (pc_r),
    .prog_len (prog_len_r),
    .res      (res),
    .wr_addr  (wr_addr)
  );

  // Mark written words; the rest read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ram_we) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // Advance the counter as each instruction retires
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else if (s1_go) begin
      pc_r <= res.next_pc;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_len_r <= '0;
    end else if (cfg_wr_en) begin
      prog_len_r <= cfg_wr_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_go) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {
    (mmie_pkg::OUT_DATA_W - mmie_pkg::OUT_BITS)'(0),
    out_res_r.write_value,
    out_res_r.write_index,
    out_res_r.wrote,
    out_res_r.halted,
    out_res_r.next_pc,
    out_res_r.status
  };

  // A written result always carries an ok status
  `MMIE_ASSERT_NOW(a_wrote_ok, out_v_r && out_res_r.wrote, out_res_r.status == mmie_pkg::ST_OK,
    "write reported with error status")
  // The counter moves only when an instruction retires
  `MMIE_ASSERT_NEXT(a_pc_hold, rst_n && !s1_go, $stable(pc_r),
    "program counter changed without a retiring instruction")
  // A retired instruction always produces a result
  `MMIE_ASSERT_NEXT(a_retire_out, rst_n && s1_go, out_v_r,
    "retired instruction left no result")
  // A written word is marked valid afterwards
  `MMIE_ASSERT_NEXT(a_valid_set, rst_n && ram_we, valid_r[$past(wr_addr)],
    "written word not marked valid")

endmodule
